FILE: hw/rtl/aalr_pkg.sv
// Shared constants for the antialiased line rasterizer.
// Holds the default sizes, request kind codes, end alpha and queue depth.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package aalr_pkg;

	localparam int DEF_COORD_BITS = 13;
	localparam int DEF_FRAC_BITS  = 16;

	// Request kinds carried in tuser.
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// Endpoints sit on integer coordinates, so the end gap is one half.
	localparam logic [7:0] END_ALPHA = 8'd127;

	localparam int QUEUE_DEPTH = 2;

endpackage

FILE: hw/rtl/antialiased_line_rasterizer.sv
// Top level of the antialiased (Wu style) line rasterizer.
// Instantiates aalr_front, aalr_queue and aalr_back; uses aalr_pkg.
// Input items arrive on the s_ stream, pixel items leave on the m_ stream.
//
// Usage:
// An input item with s_tuser = start carries two integer endpoints and a
// colour. It produces four pixel items: both pixels at each endpoint.
// An input item with s_tuser = step produces the two pixels that straddle
// the line in the next inner column; with no line in progress it produces
// nothing. The pixel item that ends a line carries m_tlast high.
// The front end registers each item into a two-entry command queue, and
// the back end pops it from there when idle. A step item is popped and then
// emits its two pixels in turn. A start item first runs a bit-serial
// division for its FRAC_BITS + 1 quotient bits (one quotient bit per cycle)
// and a setup state, then emits its four pixels in turn.
// The queue lets the front end keep taking items while the back end is busy.
// Reset clears the queue, the output register and the line in progress.
// When the receiver holds m_tready low, the output item is held, the back
// end waits, the queue fills, and s_tready falls until space frees up.
`timescale 1ns / 1ps

module antialiased_line_rasterizer import aalr_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	localparam int IN_W  = ((4 * COORD_BITS + 24 + 7) / 8) * 8,
	localparam int OUT_W = ((2 * (COORD_BITS + 1) + 32 + 7) / 8) * 8,
	localparam int CMD_W = 2 + 4 * COORD_BITS + 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// From bit 0: start_x, start_y, end_x, end_y, red_in, green_in, blue_in, zeros.
	input  logic [IN_W-1:0]  s_tdata,
	// Bit 0: req_type (start or step).
	input  logic [0:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// From bit 0: pixel_x, pixel_y, red_out, green_out, blue_out, coverage_alpha, zeros.
	output logic [OUT_W-1:0] m_tdata,
	// last_pixel: high on the final pixel of a line.
	output logic             m_tlast
);

	// Classified commands between the front end and the queue.
	logic             f_valid, f_ready;
	logic [CMD_W-1:0] f_data;
	// Commands between the queue and the back end.
	logic             b_valid, b_ready;
	logic [CMD_W-1:0] b_data;

	aalr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.in_kind   (s_tuser[0]),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_data  (f_data)
	);

	aalr_queue #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	aalr_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd_data  (b_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

FILE: hw/rtl/aalr_front.sv
// Front end of the line rasterizer: takes input items and classifies them.
// Steep items get their axes swapped and all get endpoints ordered; uses aalr_pkg.
// Output is one registered command word toward the command queue.
`timescale 1ns / 1ps

module aalr_front import aalr_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	localparam int IN_W  = ((4 * COORD_BITS + 24 + 7) / 8) * 8,
	localparam int CMD_W = 2 + 4 * COORD_BITS + 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IN_W-1:0]  in_data,
	input  logic             in_kind,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output logic [CMD_W-1:0] cmd_data
);

	localparam int C = COORD_BITS;

	logic signed [C-1:0] sx, sy, ex, ey;
	logic signed [C:0]   ddx, ddy;
	logic [C:0]          adx, ady;
	logic                swp;
	logic signed [C-1:0] ax0, ay0, ax1, ay1;
	logic signed [C-1:0] ox0, oy0, ox1, oy1;
	logic                v_s1;
	logic [CMD_W-1:0]    cmd_s1;

	always_comb begin
		sx  = $signed(in_data[0 +: C]);
		sy  = $signed(in_data[C +: C]);
		ex  = $signed(in_data[2*C +: C]);
		ey  = $signed(in_data[3*C +: C]);
		ddx = {ex[C-1], ex} - {sx[C-1], sx};
		ddy = {ey[C-1], ey} - {sy[C-1], sy};
		adx = ddx[C] ? -ddx : ddx;
		ady = ddy[C] ? -ddy : ddy;
		// Steep lines walk along y, so the two axes trade places.
		swp = ady > adx;
		ax0 = swp ? sy : sx;
		ay0 = swp ? sx : sy;
		ax1 = swp ? ey : ex;
		ay1 = swp ? ex : ey;
		if (ax0 > ax1) begin
			ox0 = ax1;
			oy0 = ay1;
			ox1 = ax0;
			oy1 = ay0;
		end else begin
			ox0 = ax0;
			oy0 = ay0;
			ox1 = ax1;
			oy1 = ay1;
		end
	end

	assign in_ready  = !v_s1 || cmd_ready;
	assign cmd_valid = v_s1;
	assign cmd_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= {in_data[4*C +: 24], oy1, ox1, oy0, ox0, swp, in_kind};
		end
	end

endmodule

FILE: hw/rtl/aalr_queue.sv
// Short command queue between the front end and the back end.
// A small circular buffer with a fill count; uses aalr_pkg for its depth.
`timescale 1ns / 1ps

module aalr_queue import aalr_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != (AW+1)'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/aalr_back.sv
// Back end of the line rasterizer: line state, gradient divider, pixel output.
// Pops classified commands, runs a bit-serial division per start, and drives
// the registered output stream. Uses aalr_pkg for codes and the end alpha.
`timescale 1ns / 1ps

module aalr_back import aalr_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	localparam int CMD_W = 2 + 4 * COORD_BITS + 24,
	localparam int OUT_W = ((2 * (COORD_BITS + 1) + 32 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  logic [CMD_W-1:0] cmd_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data,
	output logic             out_last
);

	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = C + 1;
	localparam int IW = C + F + 1;
	localparam int CW = $clog2(F + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN, ST_EMIT} state_t;

	state_t        state_q;
	logic          swapped_q, active_q, is_start_q, neg_q;
	logic [C-1:0]  x0_q, y0_q, x1_q, y1_q, fin_q;
	logic [23:0]   colour_q;
	logic [C:0]    dx_q, rem_q;
	logic [F:0]    quo_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    idx_q;
	logic [PW-1:0] col_q;
	logic [IW-1:0] icpt_q;
	logic [F+1:0]  slope_q;
	logic          out_valid_q, out_last_q;
	logic [OUT_W-1:0] out_data_q;

	// Command fields.
	logic          c_kind, c_swp;
	logic [C-1:0]  c_x0, c_y0, c_x1, c_y1;
	logic [C:0]    c_dx, c_dy, c_ady;

	// Divider step.
	logic [C+1:0]  div_t, div_sub;
	logic          div_ge;

	// Line setup.
	logic signed [F+1:0] q_signed, slope_w;
	logic [IW-1:0] icpt_w;
	logic [PW-1:0] col_w;

	// Inner column weights and the result being formed.
	logic [F-1:0]  frac;
	logic [F:0]    omf;
	logic [F+8:0]  prod_hi, prod_lo;
	logic [7:0]    a_hi, a_lo;
	logic [PW-1:0] row_w;
	logic          step_last;
	logic [PW-1:0] r_col, r_row, r_px, r_py;
	logic [7:0]    r_alpha;
	logic          r_last, r_final;
	logic          out_free;
	logic          emit_now;

	assign c_kind = cmd_data[0];
	assign c_swp  = cmd_data[1];
	assign c_x0   = cmd_data[2 +: C];
	assign c_y0   = cmd_data[2 + C +: C];
	assign c_x1   = cmd_data[2 + 2*C +: C];
	assign c_y1   = cmd_data[2 + 3*C +: C];

	assign cmd_ready = state_q == ST_IDLE;
	assign out_free  = !out_valid_q || out_ready;
	assign emit_now  = (state_q == ST_EMIT) && out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	always_comb begin
		c_dx  = {c_x1[C-1], c_x1} - {c_x0[C-1], c_x0};
		c_dy  = {c_y1[C-1], c_y1} - {c_y0[C-1], c_y0};
		c_ady = c_dy[C] ? -c_dy : c_dy;

		// Restoring division of |dy| * 2^F by dx, one quotient bit a cycle.
		// The first step uses |dy| as is, since |dy| never exceeds dx.
		div_t   = (cnt_q == CW'(F)) ? {1'b0, rem_q} : {rem_q, 1'b0};
		div_ge  = div_t >= {1'b0, dx_q};
		div_sub = div_t - {1'b0, dx_q};

		q_signed = $signed({1'b0, quo_q});
		if (dx_q == '0) begin
			slope_w = $signed({2'b01, {F{1'b0}}});
		end else begin
			slope_w = neg_q ? -q_signed : q_signed;
		end
		icpt_w = {y0_q[C-1], y0_q, {F{1'b0}}} + {{(IW-F-2){slope_w[F+1]}}, slope_w};
		col_w  = {x0_q[C-1], x0_q} + PW'(1);

		frac    = icpt_q[F-1:0];
		omf     = {1'b1, {F{1'b0}}} - {1'b0, frac};
		prod_hi = {omf, 8'd0} - {8'd0, omf};
		prod_lo = {1'b0, frac, 8'd0} - {9'd0, frac};
		a_hi    = prod_hi[F+7:F];
		a_lo    = prod_lo[F+7:F];
		row_w   = icpt_q[IW-1:F];
		step_last = $signed({col_q[PW-1], col_q} + (PW+1)'(1)) >=
			$signed({fin_q[C-1], fin_q[C-1], fin_q});

		r_last  = 1'b0;
		r_final = 1'b0;
		case ({is_start_q, idx_q})
			3'b100: begin
				r_col   = {x0_q[C-1], x0_q};
				r_row   = {y0_q[C-1], y0_q};
				r_alpha = END_ALPHA;
			end
			3'b101: begin
				r_col   = {x0_q[C-1], x0_q};
				r_row   = {y0_q[C-1], y0_q} + PW'(1);
				r_alpha = 8'd0;
			end
			3'b110: begin
				r_col   = {x1_q[C-1], x1_q};
				r_row   = {y1_q[C-1], y1_q};
				r_alpha = END_ALPHA;
			end
			3'b111: begin
				r_col   = {x1_q[C-1], x1_q};
				r_row   = {y1_q[C-1], y1_q} + PW'(1);
				r_alpha = 8'd0;
				r_last  = !active_q;
				r_final = 1'b1;
			end
			3'b000: begin
				r_col   = col_q;
				r_row   = row_w;
				r_alpha = a_hi;
			end
			3'b001: begin
				r_col   = col_q;
				r_row   = row_w + PW'(1);
				r_alpha = a_lo;
				r_last  = step_last;
				r_final = 1'b1;
			end
			default: begin
				r_col   = col_q;
				r_row   = row_w;
				r_alpha = 8'd0;
			end
		endcase
		r_px = swapped_q ? r_row : r_col;
		r_py = swapped_q ? r_col : r_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			swapped_q   <= 1'b0;
			is_start_q  <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_data_q  <= '0;
			x0_q        <= '0;
			y0_q        <= '0;
			x1_q        <= '0;
			y1_q        <= '0;
			fin_q       <= '0;
			colour_q    <= '0;
			dx_q        <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			neg_q       <= 1'b0;
			col_q       <= '0;
			icpt_q      <= '0;
			slope_q     <= '0;
		end else begin
			// The output register loads a new pixel or keeps one the receiver
			// has not taken yet.
			out_valid_q <= emit_now || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (c_kind == REQ_START) begin
							swapped_q  <= c_swp;
							x0_q       <= c_x0;
							y0_q       <= c_y0;
							x1_q       <= c_x1;
							y1_q       <= c_y1;
							colour_q   <= cmd_data[2 + 4*C +: 24];
							dx_q       <= c_dx;
							rem_q      <= c_ady;
							neg_q      <= c_dy[C];
							quo_q      <= '0;
							cnt_q      <= CW'(F);
							is_start_q <= 1'b1;
							state_q    <= ST_DIV;
						end else if (active_q) begin
							is_start_q <= 1'b0;
							idx_q      <= '0;
							state_q    <= ST_EMIT;
						end
					end
				end
				ST_DIV: begin
					quo_q <= {quo_q[F-1:0], div_ge};
					rem_q <= div_ge ? div_sub[C:0] : div_t[C:0];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					slope_q  <= slope_w;
					icpt_q   <= icpt_w;
					col_q    <= col_w;
					fin_q    <= x1_q;
					active_q <= $signed(col_w) < $signed({x1_q[C-1], x1_q});
					idx_q    <= '0;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_last_q  <= r_last;
						out_data_q  <= OUT_W'({r_alpha, colour_q[23:16], colour_q[15:8],
							colour_q[7:0], r_py, r_px});
						idx_q <= idx_q + 1'b1;
						if (r_final) begin
							state_q <= ST_IDLE;
							if (!is_start_q) begin
								icpt_q <= icpt_q + {{(IW-F-2){slope_q[F+1]}}, slope_q};
								col_q  <= col_q + PW'(1);
								if (step_last) begin
									active_q <= 1'b0;
								end
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
